// File: design/tkrb_pkg.sv
package tkrb_pkg;

  typedef enum logic [2:0] {
    FN_STORE  = 3'd0,
    FN_LOSS   = 3'd1,
    FN_REWIND = 3'd2,
    FN_CLEAR  = 3'd3,
    FN_STATUS = 3'd4
  } func_e;

  localparam logic [1:0] REG_WINDOW = 2'd0;
  localparam logic [1:0] REG_SPAN   = 2'd1;
  localparam logic [1:0] REG_MAXLEN = 2'd2;
  localparam logic [1:0] REG_POOL   = 2'd3;

  localparam logic [1:0] MODE_BUFFERING = 2'd0;
  localparam logic [1:0] MODE_IDLE      = 2'd1;
  localparam logic [1:0] MODE_REWIND    = 2'd2;

  localparam int unsigned MsToUs = 1000;

  typedef struct packed {
    logic [2:0]  func;
    logic [20:0] unit_len;
    logic [63:0] unit_time;
    logic        key_unit;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic        spilled;
    logic [23:0] pool_offset;
    logic [20:0] entry_len;
    logic [63:0] entry_time;
    logic        found;
    logic [1:0]  mode;
    logic        key_avail;
    logic [31:0] stored_count;
    logic [31:0] stored_bytes;
    logic [31:0] loss_count;
  } out_item_t;

  // one ring slot: timestamp, offset, length, keyframe, held in pool
  typedef struct packed {
    logic [63:0] etime;
    logic        pooled;
    logic        key;
    logic [20:0] len;
    logic [23:0] offset;
  } slot_t;

endpackage

// File: design/tkrb_ring_mem.sv
module tkrb_ring_mem
  import tkrb_pkg::*;
#(
  parameter int unsigned AW = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  slot_t         wdata_i,
  input  logic [AW-1:0] raddr_i,
  output slot_t         rdata_o
);

  slot_t mem_q [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: design/timed_keyframe_ring_buffer.sv
// Timed keyframe ring buffer: descriptor manager for a window-bounded ring of
// video units.
// Input channel in_valid_i/in_stall_o carries one command per transaction
// (store, packet loss, rewind, clear, status). Every command yields exactly one
// result transaction on out_valid_o/out_stall_i.
// Configuration: cfg_we_i with cfg_idx_i and cfg_data_i, written while idle.
// Sequence: an accepted store passes S_STORE and S_WRITE, then an S_EVRD/S_EVCHK
// pair per evicted entry, then S_SPAN; every command ends with a scan of the live
// entries from newest down to the first pooled keyframe, an S_SCANRD/S_SCANCHK pair
// per entry visited, as the ring memory has a single registered read port.
// One item is in work at a time; in_stall_o is high from acceptance until the
// result has been taken.
// Reset clears indices, counters, mode and configuration to defaults; ring
// contents are never read before being written, so no clearing pass runs.
// When the receiver stalls, the result register holds and the block waits.
module timed_keyframe_ring_buffer
  import tkrb_pkg::*;
#(
  parameter int unsigned RING_SLOTS = 256,
  parameter int unsigned POOL_ALIGN = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(RING_SLOTS);
  localparam int unsigned LAW = $clog2(POOL_ALIGN) > 0 ? $clog2(POOL_ALIGN) : 1;
  localparam logic [AW-1:0] LastSlot = AW'(RING_SLOTS - 1);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_STORE   = 10'b0000000010,
    S_WRITE   = 10'b0000000100,
    S_EVRD    = 10'b0000001000,
    S_EVCHK   = 10'b0000010000,
    S_SPAN    = 10'b0000100000,
    S_SCANRD  = 10'b0001000000,
    S_SCANCHK = 10'b0010000000,
    S_FINISH  = 10'b0100000000,
    S_OUT     = 10'b1000000000
  } state_e;

  state_e state_q;

  logic [15:0] window_q;
  logic [23:0] span_q;
  logic [20:0] maxlen_q;
  logic [23:0] poolsz_q;

  in_item_t    item_q;
  logic [AW-1:0] head_q, tail_q, ptr_q;
  logic [AW:0]   cnt_q;
  logic [23:0] used_q;
  logic        spill_q;
  logic [63:0] newest_q, oldest_q, cutoff_q;
  logic [1:0]  mode_q;
  logic [31:0] ucnt_q, bcnt_q, lcnt_q;
  out_item_t   res_q;
  logic        out_v_q;
  logic        found_q;

  logic          we;
  logic [AW-1:0] raddr;
  slot_t         wdata, rdata;

  tkrb_ring_mem #(.AW(AW)) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(head_q),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] i);
    return (i == LastSlot) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] prv(input logic [AW-1:0] i);
    return (i == '0) ? LastSlot : i - AW'(1);
  endfunction

  // aligned length and pool fit
  logic [25:0] al_len, pool_sum;
  logic [21+LAW:0] len_up;
  always_comb begin
    len_up   = (22+LAW)'(item_q.unit_len) + (22+LAW)'(POOL_ALIGN - 1);
    al_len   = 26'((len_up / POOL_ALIGN) * POOL_ALIGN);
    pool_sum = 26'(used_q) + al_len;
  end

  logic [AW:0] live;
  always_comb begin
    live = (head_q >= tail_q) ? (AW+1)'(head_q - tail_q)
                              : (AW+1)'(RING_SLOTS) - (AW+1)'(tail_q - head_q);
  end

  logic [63:0] win_us;
  assign win_us = 64'(window_q) * 64'(MsToUs);

  assign wdata = '{etime: item_q.unit_time, pooled: !spill_q, key: item_q.key_unit,
                   len: item_q.unit_len, offset: spill_q ? 24'd0 : used_q};
  assign we    = (state_q == S_WRITE);
  assign raddr = ptr_q;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_v_q;
  assign out_data_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      window_q <= 16'd2000;
      span_q   <= 24'd500000;
      maxlen_q <= 21'd65536;
      poolsz_q <= 24'd512000;
      head_q   <= '0;
      tail_q   <= '0;
      ptr_q    <= '0;
      cnt_q    <= '0;
      used_q   <= '0;
      spill_q  <= 1'b0;
      newest_q <= '0;
      oldest_q <= '0;
      cutoff_q <= '0;
      mode_q   <= MODE_BUFFERING;
      ucnt_q   <= '0;
      bcnt_q   <= '0;
      lcnt_q   <= '0;
      out_v_q  <= 1'b0;
      found_q  <= 1'b0;
      item_q   <= '0;
      res_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WINDOW: window_q <= cfg_data_i[15:0];
          REG_SPAN:   span_q   <= cfg_data_i;
          REG_MAXLEN: maxlen_q <= cfg_data_i[20:0];
          REG_POOL:   poolsz_q <= cfg_data_i;
          default:    ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            item_q <= in_data_i;
            res_q  <= '0;
            case (in_data_i.func)
              FN_STORE: begin
                if (in_data_i.unit_len == '0 || in_data_i.unit_len > maxlen_q) begin
                  state_q <= S_SCANRD;
                  ptr_q   <= '0;
                end else begin
                  state_q <= S_STORE;
                end
              end
              FN_LOSS: begin
                mode_q <= MODE_REWIND;
                lcnt_q <= lcnt_q + 32'd1;
                state_q <= S_SCANRD;
              end
              FN_CLEAR: begin
                head_q <= '0;
                tail_q <= '0;
                used_q <= '0;
                mode_q <= MODE_BUFFERING;
                ucnt_q <= '0;
                bcnt_q <= '0;
                state_q <= S_SCANRD;
              end
              default: state_q <= S_SCANRD;
            endcase
            cnt_q <= '0;
            found_q <= 1'b0;
          end
        end
        S_STORE: begin
          if (nxt(head_q) == tail_q) tail_q <= nxt(tail_q);
          if (!spill_q && pool_sum > 26'(poolsz_q)) begin
            spill_q <= 1'b1;
            res_q.spilled <= 1'b1;
            state_q <= S_SCANRD;
          end else begin
            state_q <= S_WRITE;
          end
        end
        S_WRITE: begin
          res_q.accepted <= 1'b1;
          res_q.spilled  <= spill_q;
          res_q.pool_offset <= spill_q ? 24'd0 : used_q;
          if (!spill_q) used_q <= pool_sum[23:0];
          if (oldest_q == '0) oldest_q <= item_q.unit_time;
          newest_q <= item_q.unit_time;
          ucnt_q   <= ucnt_q + 32'd1;
          bcnt_q   <= bcnt_q + 32'(item_q.unit_len);
          head_q   <= nxt(head_q);
          cutoff_q <= (item_q.unit_time > win_us) ? item_q.unit_time - win_us : 64'd0;
          ptr_q    <= tail_q;
          state_q  <= (item_q.unit_time == '0) ? S_SPAN : S_EVRD;
        end
        S_EVRD: begin
          if (tail_q == head_q) begin
            used_q  <= '0;
            state_q <= S_SPAN;
          end else begin
            state_q <= S_EVCHK;
          end
        end
        S_EVCHK: begin
          if (rdata.etime >= cutoff_q) begin
            state_q <= S_SPAN;
          end else begin
            oldest_q <= rdata.etime;
            tail_q   <= nxt(tail_q);
            ptr_q    <= nxt(tail_q);
            state_q  <= S_EVRD;
          end
        end
        S_SPAN: begin
          if (mode_q == MODE_BUFFERING && (newest_q - oldest_q) >= 64'(span_q))
            mode_q <= MODE_IDLE;
          state_q <= S_SCANRD;
        end
        S_SCANRD: begin
          // start walk from newest entry
          if (cnt_q == '0) begin
            ptr_q <= prv(head_q);
            cnt_q <= (AW+1)'(1);
            if (live == '0) state_q <= S_FINISH;
          end else begin
            state_q <= S_SCANCHK;
          end
        end
        S_SCANCHK: begin
          if (rdata.pooled && rdata.key) begin
            found_q <= 1'b1;
            state_q <= S_FINISH;
            if (item_q.func == FN_REWIND) begin
              res_q.found       <= 1'b1;
              res_q.pool_offset <= rdata.offset;
              res_q.entry_len   <= rdata.len;
              res_q.entry_time  <= rdata.etime;
              head_q <= nxt(ptr_q);
              mode_q <= MODE_BUFFERING;
            end
          end else if (cnt_q >= live) begin
            state_q <= S_FINISH;
          end else begin
            ptr_q   <= prv(ptr_q);
            cnt_q   <= cnt_q + (AW+1)'(1);
            state_q <= S_SCANRD;
          end
        end
        S_FINISH: begin
          res_q.mode         <= mode_q;
          res_q.key_avail    <= found_q;
          res_q.stored_count <= ucnt_q;
          res_q.stored_bytes <= bcnt_q;
          res_q.loss_count   <= lcnt_q;
          out_v_q <= 1'b1;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall_i) begin
            out_v_q <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> state_q == S_OUT)
    else $error("result valid outside output state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_stall_i) |=> $stable(res_q))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> !spill_q || wdata.offset == '0)
    else $error("spilled entry written with offset");

endmodule

// File: dv/timed_keyframe_ring_buffer_test.sv
module timed_keyframe_ring_buffer_test;
  import tkrb_pkg::*;

  localparam int unsigned Slots = 256;
  localparam int unsigned Align = 64;

  class ring_scoreboard;
    logic [63:0] slot_time [Slots];
    logic [23:0] slot_off [Slots];
    logic [20:0] slot_len [Slots];
    bit          slot_key [Slots];
    bit          slot_pool [Slots];
    bit [7:0]    head, tail;
    longint unsigned pool_used, newest, oldest;
    bit          spill;
    logic [1:0]  run_mode;
    bit [31:0]   units, bytes, losses;
    longint unsigned window_ms, ready_span, max_len, pool_size;
    out_item_t   pending[$];
    int          errors;

    function new();
      head = 0; tail = 0; pool_used = 0; newest = 0; oldest = 0; spill = 0;
      run_mode = MODE_BUFFERING; units = 0; bytes = 0; losses = 0;
      window_ms = 2000; ready_span = 500000; max_len = 65536; pool_size = 512000;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [23:0] val);
      case (idx)
        REG_WINDOW: window_ms = val[15:0];
        REG_SPAN:   ready_span = val;
        REG_MAXLEN: max_len = val[20:0];
        default:    pool_size = val;
      endcase
    endfunction

    // newest live keyframe with pool data, -1 if none
    function int newest_key();
      bit [7:0] idx;
      bit [7:0] live;
      live = head - tail;
      idx = head;
      for (int n = 0; n < live; n++) begin
        idx = idx - 8'd1;
        if (slot_pool[idx] && slot_key[idx]) return int'(idx);
      end
      return -1;
    endfunction

    function void evict_aged();
      longint unsigned span, cutoff;
      span = window_ms * 1000;
      if (newest == 0) return;
      cutoff = newest > span ? newest - span : 0;
      while (tail != head && slot_time[tail] < cutoff) begin
        oldest = slot_time[tail];
        tail = tail + 8'd1;
      end
      if (tail == head) pool_used = 0;
    endfunction

    function void note_command(in_item_t it);
      out_item_t e;
      longint unsigned al;
      bit [7:0] nxt;
      int k;
      e = '0;
      case (it.func)
        FN_STORE: begin
          if (it.unit_len != 0 && it.unit_len <= max_len) begin
            bit pooled, record;
            pooled = 0; record = 1;
            nxt = head + 8'd1;
            if (nxt == tail) tail = tail + 8'd1;
            if (!spill) begin
              al = ((it.unit_len + Align - 1) / Align) * Align;
              if (pool_used + al > pool_size) begin
                spill = 1; e.spilled = 1; record = 0;
              end else begin
                e.pool_offset = 24'(pool_used);
                pool_used = (pool_used + al) & 64'hFFFFFF;
                pooled = 1;
              end
            end else begin
              e.spilled = 1;
            end
            if (record) begin
              e.accepted = 1;
              slot_time[head] = it.unit_time;
              slot_off[head] = e.pool_offset;
              slot_len[head] = it.unit_len;
              slot_key[head] = it.key_unit;
              slot_pool[head] = pooled;
              if (oldest == 0) oldest = it.unit_time;
              newest = it.unit_time;
              units += 1;
              bytes += 32'(it.unit_len);
              head = nxt;
              evict_aged();
              if (run_mode == MODE_BUFFERING && newest - oldest >= ready_span)
                run_mode = MODE_IDLE;
            end
          end
        end
        FN_LOSS: begin
          run_mode = MODE_REWIND;
          losses += 1;
        end
        FN_REWIND: begin
          k = newest_key();
          if (k >= 0) begin
            e.found = 1;
            e.pool_offset = slot_off[k];
            e.entry_len = slot_len[k];
            e.entry_time = slot_time[k];
            head = 8'(k + 1);
            run_mode = MODE_BUFFERING;
          end
        end
        FN_CLEAR: begin
          head = 0; tail = 0; pool_used = 0; run_mode = MODE_BUFFERING;
          units = 0; bytes = 0;
        end
        default: ;
      endcase
      e.mode = run_mode;
      e.key_avail = (head != tail && newest_key() >= 0);
      e.stored_count = units;
      e.stored_bytes = bytes;
      e.loss_count = losses;
      pending.push_back(e);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task cmp(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_result(out_item_t got);
      out_item_t w;
      if (pending.size() == 0) begin
        report("result with nothing outstanding");
        return;
      end
      w = pending.pop_front();
      cmp("accepted", got.accepted, w.accepted);
      cmp("spilled", got.spilled, w.spilled);
      cmp("pool_offset", got.pool_offset, w.pool_offset);
      cmp("entry_len", got.entry_len, w.entry_len);
      cmp("entry_time", got.entry_time, w.entry_time);
      cmp("found", got.found, w.found);
      cmp("mode", got.mode, w.mode);
      cmp("key_avail", got.key_avail, w.key_avail);
      cmp("stored_count", got.stored_count, w.stored_count);
      cmp("stored_bytes", got.stored_bytes, w.stored_bytes);
      cmp("loss_count", got.loss_count, w.loss_count);
    endtask
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  out_item_t   out_data_o;
  logic        cfg_we_i = 0;
  logic [1:0]  cfg_idx_i = REG_WINDOW;
  logic [23:0] cfg_data_i = '0;

  ring_scoreboard sb = new();
  bit idling = 1;
  int stall_left = 0;
  longint unsigned now_us = 0;

  timed_keyframe_ring_buffer i_dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  always @(posedge clk_i)
    if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i = 1;
    end else if (idling && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 11);
      out_stall_i = 1;
    end else begin
      out_stall_i = 0;
    end
  end

  // called at a falling edge; returns at a falling edge after acceptance
  task send(in_item_t it);
    if (idling && $urandom_range(0, 7) == 0) begin
      in_valid_i = 0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    in_valid_i = 1;
    in_data_i = it;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    sb.note_command(it);
    @(negedge clk_i);
  endtask

  task send_cmd(func_e f, logic [20:0] len, logic [63:0] t, bit key);
    in_item_t it;
    it.func = f; it.unit_len = len; it.unit_time = t; it.key_unit = key;
    send(it);
  endtask

  // drain outstanding results, then let any in-flight scan finish
  task settle();
    in_valid_i = 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (600) @(negedge clk_i);
  endtask

  task write_reg(logic [1:0] idx, logic [23:0] val);
    cfg_we_i = 1; cfg_idx_i = idx; cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 0;
    sb.set_reg(idx, val);
  endtask

  task setup(logic [23:0] win, logic [23:0] span, logic [23:0] mlen, logic [23:0] pool);
    settle();
    write_reg(REG_WINDOW, win);
    write_reg(REG_SPAN, span);
    write_reg(REG_MAXLEN, mlen);
    write_reg(REG_POOL, pool);
  endtask

  task run_random(int count, int step_max);
    in_item_t it;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      it.unit_time = now_us;
      it.key_unit = ($urandom_range(0, 7) == 0);
      it.unit_len = 21'($urandom_range(1, 4000));
      if (r < 80) begin
        it.func = FN_STORE;
        now_us += $urandom_range(0, step_max);
        it.unit_time = now_us;
        case ($urandom_range(0, 19))
          0: it.unit_len = 21'($urandom_range(0, 2097151));
          1: it.unit_len = 21'($urandom_range(1, 1048576));
          2: it.unit_time = {$urandom, $urandom};
          default: ;
        endcase
      end else if (r < 85) it.func = FN_REWIND;
      else if (r < 89) it.func = FN_LOSS;
      else if (r < 91) it.func = FN_CLEAR;
      else if (r < 95) it.func = FN_STATUS;
      else it.func = func_e'($urandom_range(5, 7));
      if (it.func != FN_STORE && $urandom_range(0, 1)) begin
        it.unit_len = 21'($urandom_range(0, 2097151));
        it.unit_time = {$urandom, $urandom};
      end
      send(it);
    end
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    setup(2000, 500000, 65536, 512000);
    send_cmd(FN_STATUS, 0, 0, 0);
    send_cmd(FN_REWIND, 0, 0, 0);
    send_cmd(FN_STORE, 0, 5000, 1);
    send_cmd(FN_STORE, 65537, 5000, 1);
    send_cmd(FN_STORE, 2097151, 64'hFFFF_FFFF_FFFF_FFFF, 1);
    send_cmd(FN_STORE, 1, 0, 1);
    send_cmd(FN_STORE, 65536, 1000, 0);
    send_cmd(FN_STORE, 64, 300000, 1);
    send_cmd(FN_STORE, 65, 700000, 0);
    send_cmd(FN_LOSS, 0, 0, 0);
    send_cmd(FN_REWIND, 0, 0, 0);
    send_cmd(FN_STORE, 100, 3000000, 0);
    send_cmd(FN_REWIND, 0, 0, 0);
    send_cmd(FN_STORE, 100, 64'hFFFF_FFFF_FFFF_FFFF, 1);
    send_cmd(FN_STATUS, 0, 0, 0);
    send_cmd(func_e'(3'd5), 0, 0, 0);
    send_cmd(func_e'(3'd6), 2097151, 64'hFFFF_FFFF_FFFF_FFFF, 1);
    send_cmd(func_e'(3'd7), 0, 0, 0);
    send_cmd(FN_CLEAR, 0, 0, 0);
    send_cmd(FN_STORE, 10, 1, 1);
    now_us = 10;
    run_random(350, 40000);

    // long window, huge pool: ring wraps and drops oldest
    setup(65535, 16777215, 1048576, 16777215);
    send_cmd(FN_CLEAR, 0, 0, 0);
    run_random(450, 2000);

    // tiny window, zero span: heavy eviction, pool reclaim
    setup(1, 0, 1048576, 16777215);
    run_random(400, 1500);

    // single-byte limit then empty pool: spill from here on
    setup(65535, 16777215, 1, 0);
    run_random(250, 30000);

    setup(3000, 200000, 20000, 300000);
    run_random(250, 30000);
    idling = 0;
    settle();
    run_random(300, 30000);

    settle();
    if (sb.errors == 0 && sb.pending.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #100_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
